FILE: rtl/aas_pkg.sv
// Shared constants, item types and entry layout for the aging address set.
package aas_pkg;

  // Table geometry.
  localparam int ENTRIES   = 16;
  localparam int ADDR_BITS = 32;

  // Derived widths: slot index, and entry counter (at least 5 bits so the
  // result fields can always take the low five bits).
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_RAW_W = $clog2(ENTRIES + 1);
  localparam int CNT_W     = (CNT_RAW_W < 5) ? 5 : CNT_RAW_W;

  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // Item kinds.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_SWEEP  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] valid_seconds;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       added;
    logic       found;
    logic [4:0] removed_count;
    logic [4:0] entry_count;
    logic       changed;
    logic       table_full;
  } out_item_t;

  // One stored entry: address and absolute expiry time in milliseconds.
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/aas_in_if.sv
// Valid/ready channel that carries one input transaction of the address set.
interface aas_in_if
  import aas_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/aas_out_if.sv
// Valid/ready channel that carries one result transaction of the address set.
interface aas_out_if
  import aas_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/aging_address_set.sv
// Aging address set: a small table of addresses with expiry times, scanned by a sequencer.
//
// The block holds up to ENTRIES addresses, each with an absolute expiry time
// in milliseconds. An input transaction is an update, a lookup or a timeout
// sweep, and each one yields exactly one result transaction. Addresses and
// expiry times live in one RAM. Only the per-slot valid bits and the entry
// count are flip-flops, so reset clears the table at once and no clearing
// pass is needed. Every update, lookup and sweep walks the RAM one slot per
// cycle. It uses a single read port, a single address comparator and a single
// expiry subtractor. The scan state issues the reads in slot order, the last
// state evaluates the slot read last, and the commit state writes the
// result register. The input is ready again once the commit is done. An
// item of the unused fourth kind skips the walk and goes straight from idle
// to the commit state. The input is ready only while the sequencer is idle.
// A finished result sits in an output register, and the block already takes
// the next transaction while that result waits for the consumer. The commit
// step stalls for as long as an earlier result is still waiting. An update
// refreshes the expiry of an address that is present. Otherwise it claims
// the lowest free slot or reports table_full. A sweep drops every entry
// whose expiry lies before now_ms, using the wrap-safe test on bit 31 of
// expiry minus now_ms; an expiry equal to now_ms is still alive.
module aging_address_set
  import aas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  aas_in_if.sink    req,
  aas_out_if.source rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  state_t state;

  // Latched item.
  logic [1:0]           cur_kind;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [31:0]          cur_now;
  logic [31:0]          cur_expiry;

  // Scan bookkeeping.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pend;
  logic             hit;
  logic [IDX_W-1:0] hit_slot;
  logic             free_ok;
  logic [IDX_W-1:0] free_slot;
  logic [CNT_W-1:0] removed;

  // Table state held in flip-flops.
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]   held_count;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic [31:0] expiry_diff;
  logic        expired;
  logic        addr_match;
  logic        out_free;
  logic [25:0] secs_ms;

  aas_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // The shared datapath: one address comparator and one expiry subtractor,
  // applied to whichever slot the RAM returned this cycle.
  assign expiry_diff = ram_rdata.expiry - cur_now;
  assign expired     = expiry_diff[31];
  assign addr_match  = (ram_rdata.addr == cur_addr);

  assign secs_ms  = 26'(req.data.valid_seconds) * 26'(MS_PER_SECOND);
  assign out_free = !rsp.valid || rsp.ready;

  assign req.ready = (state == ST_IDLE);

  // An update writes the whole entry; on a refresh the stored address equals
  // the latched one, so rewriting it is harmless.
  assign ram_we    = (state == ST_COMMIT) && out_free && (cur_kind == KIND_UPDATE) &&
                     (hit || free_ok);
  assign ram_waddr = hit ? hit_slot : free_slot;
  assign ram_wdata = '{addr: cur_addr, expiry: cur_expiry};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_valid <= '0;
      held_count  <= '0;
      rd_pend     <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      // Evaluate the slot whose read data arrived this cycle.
      if (rd_pend) begin
        if (entry_valid[rd_idx] && addr_match && !hit) begin
          hit      <= 1'b1;
          hit_slot <= rd_idx;
        end
        if (!entry_valid[rd_idx] && !free_ok) begin
          free_ok   <= 1'b1;
          free_slot <= rd_idx;
        end
        if ((cur_kind == KIND_SWEEP) && entry_valid[rd_idx] && expired) begin
          entry_valid[rd_idx] <= 1'b0;
          held_count          <= held_count - 1'b1;
          removed             <= removed + 1'b1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur_kind   <= req.data.kind;
            cur_addr   <= ADDR_BITS'(req.data.address);
            cur_now    <= req.data.now_ms;
            cur_expiry <= req.data.now_ms + 32'(secs_ms);
            idx        <= '0;
            hit        <= 1'b0;
            free_ok    <= 1'b0;
            removed    <= '0;
            if (req.data.kind inside {KIND_UPDATE, KIND_LOOKUP, KIND_SWEEP}) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_COMMIT;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= 1'b1;
          rd_idx  <= idx;
          if (idx == IDX_W'(ENTRIES - 1)) begin
            state <= ST_LAST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_LAST: begin
          rd_pend <= 1'b0;
          state   <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            rsp.data  <= '0;
            rsp.data.entry_count <= held_count[4:0];
            case (cur_kind)
              KIND_UPDATE: begin
                if (hit) begin
                  rsp.data.found <= 1'b1;
                end else if (free_ok) begin
                  entry_valid[free_slot] <= 1'b1;
                  held_count             <= held_count + 1'b1;
                  rsp.data.entry_count   <= 5'(held_count + 1'b1);
                  rsp.data.added         <= 1'b1;
                  rsp.data.changed       <= 1'b1;
                end else begin
                  rsp.data.table_full <= 1'b1;
                end
              end
              KIND_LOOKUP: begin
                rsp.data.found <= hit;
              end
              KIND_SWEEP: begin
                rsp.data.removed_count <= removed[4:0];
                rsp.data.changed       <= (removed != '0);
              end
              default: begin
              end
            endcase
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The entry count always tracks the number of occupied slots.
  assert property (@(posedge clk) disable iff (rst)
    held_count == CNT_W'($countones(entry_valid)))
    else $error("entry count disagrees with the valid bits");

  // A new result only ever appears out of the commit step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_COMMIT))
    else $error("result presented outside the commit step");

  // The entry RAM is written only at commit, never during a scan.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_COMMIT) && (cur_kind == KIND_UPDATE))
    else $error("entry RAM written outside an update commit");

  // An update either refreshes, inserts or is refused, never two at once.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $countones({rsp.data.found, rsp.data.added, rsp.data.table_full}) <= 1)
    else $error("conflicting update outcome flags");

endmodule

FILE: rtl/aas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/aging_address_set_test.sv
// Self-checking testbench for the aging address set: directed plan, then random traffic.
module aging_address_set_test;
  import aas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The package names the three real kinds only. The fourth encoding is
  // ignored by the block, and the testbench still exercises it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [31:0] MS_IN_SECOND = 32'd1000;

  // A transaction spends a whole table walk inside the block. The receiver
  // can stall for a while, and the sender can pause too. A quiet spell that
  // reaches QUIET_LIMIT with no handshake on either channel means a hang.
  localparam int QUIET_LIMIT = 2000;

  // The number of cycles to wait once nothing is pending, so that a stray
  // extra result would still get caught.
  localparam int TAIL_CYCLES = 4 * (ENTRIES + 3);

  localparam int RANDOM_ITEMS = 1200;
  localparam int POOL_SIZE    = 24;

  logic clk = 1'b0;
  logic rst;

  aas_in_if  in_ch ();
  aas_out_if out_ch ();

  aging_address_set u_dut (
    .clk (clk),
    .rst (rst),
    .req (in_ch),
    .rsp (out_ch)
  );

  always #6 clk = ~clk;

  // Testbench copy of the table state. The predictor only ever uses
  // an address or expiry of a slot whose live bit is set. That matches
  // the block, whose RAM holds no defined contents until written.
  logic        slot_live   [ENTRIES];
  logic [31:0] slot_addr   [ENTRIES];
  logic [31:0] slot_expiry [ENTRIES];
  int          held_entries;

  // Expected results, oldest first. One is pushed for every input transaction.
  out_item_t results_due [$];

  int errors      = 0;
  int quiet_cycles = 0;

  // While this is set, neither side inserts idle cycles.
  bit steady = 1'b0;

  // The directed plan. A row may repeat its item with the address counting
  // up, which fills the table without a row for every slot. A row with
  // `typed` set carries its expected result. The predictor covers the others.
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t result;
  } plan_row_t;

  plan_row_t directed_plan [$];

  // Applies one accepted item to the testbench copy of the table and returns
  // the result that the block must produce for it.
  function automatic out_item_t step_address_set(input in_item_t item);
    out_item_t   res;
    logic [31:0] expiry;
    logic [31:0] margin;
    int          hit;
    int          free_idx;
    int          dropped;
    res      = '0;
    hit      = -1;
    free_idx = -1;
    dropped  = 0;
    expiry   = item.now_ms + 32'(item.valid_seconds) * MS_IN_SECOND;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_addr[i] == item.address && hit < 0) hit = i;
      if (!slot_live[i] && free_idx < 0) free_idx = i;
    end
    case (item.kind)
      KIND_UPDATE: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          slot_expiry[hit] = expiry;
        end else if (free_idx >= 0) begin
          slot_live[free_idx]   = 1'b1;
          slot_addr[free_idx]   = item.address;
          slot_expiry[free_idx] = expiry;
          held_entries++;
          res.added   = 1'b1;
          res.changed = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        res.found = (hit >= 0);
      end
      KIND_SWEEP: begin
        // An entry has timed out when its expiry lies before now on the
        // wrapping millisecond clock. That is the case when the sign bit of
        // expiry minus now is set. An expiry equal to now is still alive.
        for (int i = 0; i < ENTRIES; i++) begin
          margin = slot_expiry[i] - item.now_ms;
          if (slot_live[i] && margin[31]) begin
            slot_live[i] = 1'b0;
            dropped++;
          end
        end
        held_entries -= dropped;
        res.removed_count = 5'(dropped);
        res.changed       = (dropped != 0);
      end
      default: ;
    endcase
    res.entry_count = 5'(held_entries);
    return res;
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [31:0] address,
                         input logic [15:0] secs, input logic [31:0] now,
                         input int reps, input bit typed, input out_item_t result);
    plan_row_t row;
    row.item   = '{kind: kind, address: address, valid_seconds: secs, now_ms: now};
    row.reps   = reps;
    row.typed  = typed;
    row.result = result;
    directed_plan.push_back(row);
  endtask

  // Offers one transaction. The sender may idle for some cycles first, and
  // then it holds valid until the block takes the transaction. The task
  // returns at the accepting edge and leaves valid high. The next call
  // either lowers valid or presents the next item in that same time step,
  // so valid never gets two assignments in one step.
  task automatic drive_item(input in_item_t item);
    while (!steady && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and holds off until every outstanding result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic compare_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // The receiver accepts results with random back-pressure, unless the
  // stimulus has asked for a steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 28);
  end

  // Result checker. Every result transaction is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, actual %p", $time, out_ch.data);
      end else begin
        out_item_t want;
        want = results_due.pop_front();
        compare_field("added",         5'(want.added),      5'(out_ch.data.added));
        compare_field("found",         5'(want.found),      5'(out_ch.data.found));
        compare_field("removed_count", want.removed_count,  out_ch.data.removed_count);
        compare_field("entry_count",   want.entry_count,    out_ch.data.entry_count);
        compare_field("changed",       5'(want.changed),    5'(out_ch.data.changed));
        compare_field("table_full",    5'(want.table_full), 5'(out_ch.data.table_full));
      end
    end
  end

  // Watchdog. The count restarts whenever a transaction moves on either
  // channel. A long quiet spell means the block has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("aging_address_set_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t    item;
    out_item_t   want;
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] wall_ms;
    int          pick;
    int          step_max;

    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
    held_entries = 0;

    // Directed plan. The expected results of the early rows follow directly
    // from an empty table. Once the table holds a mix of entries, the
    // predictor takes over.
    // Lookup and sweep on an empty table, then the ignored kind with every
    // field at its maximum.
    add_row(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0});
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0});
    add_row(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0});
    // Every field at its maximum. The expiry wraps past 2^32.
    add_row(KIND_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1,
            out_item_t'{1'b1, 1'b0, 5'd0, 5'd1, 1'b1, 1'b0});
    add_row(KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b1, 5'd0, 5'd1, 1'b0, 1'b0});
    // Insert with zero validity, then refresh it to expire at 5100 ms.
    add_row(KIND_UPDATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b1, 1'b0, 5'd0, 5'd2, 1'b1, 1'b0});
    add_row(KIND_UPDATE, 32'h0000_0000, 16'h0005, 32'h0000_0064, 1, 1'b1,
            out_item_t'{1'b0, 1'b1, 5'd0, 5'd2, 1'b0, 1'b0});
    add_row(KIND_LOOKUP, 32'h1234_5678, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'd2, 1'b0, 1'b0});
    // An expiry equal to now survives. One millisecond later, it is swept.
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'd5100, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'd2, 1'b0, 1'b0});
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'd5101, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd1, 5'd1, 1'b1, 1'b0});
    // Fill the table up to its last free slot, then take that slot too.
    add_row(KIND_UPDATE, 32'h8000_0000, 16'h0001, 32'h0000_0000, ENTRIES - 2, 1'b0, '0);
    add_row(KIND_UPDATE, 32'hA5A5_A5A5, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b1, 1'b0, 5'd0, 5'(ENTRIES), 1'b1, 1'b0});
    // A full table refuses a new address, but still refreshes an old one.
    add_row(KIND_UPDATE, 32'h5A5A_5A5A, 16'h0003, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'(ENTRIES), 1'b0, 1'b1});
    add_row(KIND_UPDATE, 32'hFFFF_FFFF, 16'h0002, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b1, 5'd0, 5'(ENTRIES), 1'b0, 1'b0});
    add_row(KIND_LOOKUP, 32'h5A5A_5A5A, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'(ENTRIES), 1'b0, 1'b0});
    add_row(KIND_UNUSED, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1'b1,
            out_item_t'{1'b0, 1'b0, 5'd0, 5'(ENTRIES), 1'b0, 1'b0});
    // Sweeps at 2000 ms, at the halfway point of the wrapping clock and at its maximum.
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'h0000_07D0, 1, 1'b0, '0);
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'h8000_0000, 1, 1'b0, '0);
    add_row(KIND_UPDATE, 32'h7FFF_FFFF, 16'h8000, 32'h7FFF_FFFF, 1, 1'b0, '0);
    add_row(KIND_SWEEP, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 1, 1'b0, '0);
    add_row(KIND_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, 1, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      for (int k = 0; k < directed_plan[r].reps; k++) begin
        item = directed_plan[r].item;
        item.address = item.address + 32'(k);
        drive_item(item);
        want = step_address_set(item);
        results_due.push_back(directed_plan[r].typed ? directed_plan[r].result : want);
      end
    end

    // Let the directed part fully drain before the random traffic starts.
    drain_results();

    // Random traffic. Most addresses come from a small pool that is a bit
    // larger than the table. The same addresses get refreshed, looked up
    // and aged out over and over, and the table regularly fills up.
    // Time mostly moves forward in modest steps from just below the wrap
    // point. Now and then there is a jump, or an item carries an
    // unrelated now_ms, so that sweeps judge entries across the whole
    // wrapping range. Validity is mostly a few seconds. Rare long
    // validities reach the top bits of the field.
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    wall_ms = 32'hFFF0_0000 + $urandom_range(65535);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Neither side idles for a stretch in the middle of the run.
      steady = (n >= 400 && n < 600);
      if (n == 700) drain_results();

      step_max = ((n / 150) % 2 == 1) ? 3000 : 300;
      if ($urandom_range(99) == 0) wall_ms = $urandom;
      else wall_ms = wall_ms + $urandom_range(step_max);

      pick = $urandom_range(99);
      if (pick < 45)      item.kind = KIND_UPDATE;
      else if (pick < 70) item.kind = KIND_LOOKUP;
      else if (pick < 96) item.kind = KIND_SWEEP;
      else                item.kind = KIND_UNUSED;

      item.address       = ($urandom_range(9) == 0) ? 32'($urandom)
                                                    : pool[$urandom_range(POOL_SIZE - 1)];
      item.valid_seconds = ($urandom_range(49) == 0) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(20));
      item.now_ms        = ($urandom_range(19) == 0) ? 32'($urandom) : wall_ms;

      drive_item(item);
      results_due.push_back(step_address_set(item));
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait for the last results, then a little longer in case a stray
    // extra result shows up. The watchdog bounds this wait.
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && results_due.size() == 0) begin
      $display("aging_address_set_test: PASS");
    end else begin
      $display("aging_address_set_test: FAIL");
    end
    $finish;
  end

endmodule
